/* rtl/mbe_pkg.sv */
// shared types, constants and helpers for the escape-time unit
package mbe_pkg;

  localparam int MAX_ITER  = 256;
  localparam int CNT_W     = $clog2(MAX_ITER + 1);
  localparam int COORD_W   = 10;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int Q_FRAC    = 28;
  localparam int CNT_OUT_W = 9;
  localparam int COUNT_SAT = 511;

  // |z|^2 limit of 4.0 in Q8.56
  localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * Q_FRAC);

  localparam logic signed [WORD_W-1:0] RST_REAL_LEFT = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] RST_REAL_STEP = 32'sd1258291;
  localparam logic signed [WORD_W-1:0] RST_IMAG_TOP  = 32'sd268435456;
  localparam logic signed [WORD_W-1:0] RST_IMAG_STEP = -32'sd1118481;

  typedef enum logic [1:0] {
    CFG_REAL_LEFT,
    CFG_REAL_STEP,
    CFG_IMAG_TOP,
    CFG_IMAG_STEP
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } mbe_in_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] escape_count;
    logic                 plot;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
  } mbe_out_t;

  // clamp a wide signed value to the Q4.28 word range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < 64'shffff_ffff_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/mandelbrot_escape_time_unit.sv */
// top level: pixel mapping and z = z*z + c escape-time sequencer
//
//   channel  ports                             handshake
//   input    start, busy, in_item              taken when start && !busy
//   result   out_valid, out_item               one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_index, cfg_wdata      written when cfg_we is high
//
// one multiplier is shared by mapping and iteration, one product per cycle,
// so each round steps through the states x*x, y*y, x*y and update
// busy stays high for the whole item; a new item may start while the strobe is up
// synchronous active-low reset restores the default view window registers
module mandelbrot_escape_time_unit
  import mbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mbe_in_t             in_item,
  output logic                out_valid,
  output mbe_out_t            out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [WORD_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_MAPC,
    S_XX,
    S_YY,
    S_XY,
    S_UPD
  } state_t;

  state_t                   state_r;
  logic signed [WORD_W-1:0] real_left_r, real_step_r, imag_top_r, imag_step_r;
  logic [COORD_W-1:0]       px_r, py_r;
  logic signed [WORD_W-1:0] cr_r, ci_r, x_r, y_r;
  logic signed [PROD_W-1:0] xx_r, diff_r;
  logic [CNT_W-1:0]         k_r;
  logic                     out_valid_r;
  mbe_out_t                 out_item_r;

  logic signed [WORD_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        mag_sum;
  logic                     escaped;
  logic                     at_limit;
  logic [CNT_W-1:0]         fin_cnt;
  logic signed [PROD_W-1:0] nx_wide, ny_wide;

  mbe_mult u_mult (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // operand select for the shared multiplier
  always_comb begin
    unique case (state_r)
      S_MAPX: begin
        mul_a = $signed(WORD_W'(px_r));
        mul_b = real_step_r;
      end
      S_MAPY: begin
        mul_a = $signed(WORD_W'(py_r));
        mul_b = imag_step_r;
      end
      S_XX: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      S_XY: begin
        mul_a = x_r;
        mul_b = y_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = y_r;
      end
    endcase
  end

  // in S_XY prod_r holds y*y of the current z
  assign mag_sum  = $unsigned(xx_r) + $unsigned(prod_r);
  assign escaped  = (k_r != '0) && (mag_sum > ESC_LIMIT);
  assign at_limit = (k_r == CNT_W'(MAX_ITER));
  assign fin_cnt  = escaped ? (k_r - CNT_W'(1)) : k_r;

  // arithmetic shift right is the floor division by a power of two
  assign nx_wide = (diff_r >>> Q_FRAC) + PROD_W'(cr_r);
  assign ny_wide = (prod_r >>> (Q_FRAC - 1)) + PROD_W'(ci_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      real_left_r <= RST_REAL_LEFT;
      real_step_r <= RST_REAL_STEP;
      imag_top_r  <= RST_IMAG_TOP;
      imag_step_r <= RST_IMAG_STEP;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_REAL_LEFT: real_left_r <= cfg_wdata;
          CFG_REAL_STEP: real_step_r <= cfg_wdata;
          CFG_IMAG_TOP:  imag_top_r  <= cfg_wdata;
          CFG_IMAG_STEP: imag_step_r <= cfg_wdata;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            px_r    <= in_item.pixel_x;
            py_r    <= in_item.pixel_y;
            state_r <= S_MAPX;
          end
        end
        S_MAPX: begin
          state_r <= S_MAPY;
        end
        S_MAPY: begin
          cr_r    <= sat32(PROD_W'(real_left_r) + prod_r);
          x_r     <= sat32(PROD_W'(real_left_r) + prod_r);
          state_r <= S_MAPC;
        end
        S_MAPC: begin
          ci_r    <= sat32(PROD_W'(imag_top_r) + prod_r);
          y_r     <= sat32(PROD_W'(imag_top_r) + prod_r);
          k_r     <= '0;
          state_r <= S_XX;
        end
        S_XX: begin
          state_r <= S_YY;
        end
        S_YY: begin
          xx_r    <= prod_r;
          state_r <= S_XY;
        end
        S_XY: begin
          diff_r <= xx_r - prod_r;
          if (escaped || at_limit) begin
            out_valid_r <= 1'b1;
            out_item_r.escape_count <= (32'(fin_cnt) > 32'(COUNT_SAT)) ?
                                       CNT_OUT_W'(COUNT_SAT) : CNT_OUT_W'(fin_cnt);
            out_item_r.plot  <= (fin_cnt == '0) || (fin_cnt == CNT_W'(MAX_ITER));
            out_item_r.out_x <= px_r;
            out_item_r.out_y <= py_r;
            state_r          <= S_IDLE;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          x_r     <= sat32(nx_wide);
          y_r     <= sat32(ny_wide);
          k_r     <= k_r + CNT_W'(1);
          state_r <= S_XX;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= CNT_W'(MAX_ITER))
    else $error("round counter passed the iteration limit");

  a_plot_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.escape_count == '0)) |-> out_item.plot)
    else $error("plot flag missing for an immediate escape");

endmodule

/* rtl/mbe_mult.sv */
// shared signed 32x32 multiplier with registered product
module mbe_mult
  import mbe_pkg::*;
(
  input  logic                     clk,
  input  logic signed [WORD_W-1:0] mul_a,
  input  logic signed [WORD_W-1:0] mul_b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

/* dv/tb_mandelbrot_escape_time_unit.sv */
// self-checking testbench for the mandelbrot escape-time unit
`timescale 1ns / 100ps

module tb_mandelbrot_escape_time_unit;
  import mbe_pkg::*;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  mbe_in_t           in_item = '0;
  logic              out_valid;
  mbe_out_t          out_item;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = '0;
  logic [WORD_W-1:0] cfg_wdata = '0;

  // local copy of the view window registers
  logic signed [WORD_W-1:0] view_real_left = RST_REAL_LEFT;
  logic signed [WORD_W-1:0] view_real_step = RST_REAL_STEP;
  logic signed [WORD_W-1:0] view_imag_top  = RST_IMAG_TOP;
  logic signed [WORD_W-1:0] view_imag_step = RST_IMAG_STEP;

  mbe_in_t  pending_pixels[$];
  mbe_out_t expected_results[$];
  int       send_idle_pct = 36;
  int       mismatch_count = 0;
  logic     item_taken = 1'b0;

  mandelbrot_escape_time_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(100_000_000);
    $display("[mandelbrot_escape_time_unit] ERROR");
    $finish;
  end

  function automatic longint clamp_q428(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r;
  endfunction

  // map the pixel into the window and iterate z = z*z + c until |z|^2 > 4 or MAX_ITER rounds are reached
  function automatic mbe_out_t escape_result(input mbe_in_t pix);
    longint      cr, ci, zr, zi, nr, ni;
    logic [63:0] mag;
    int          rounds;
    bit          escaped;
    mbe_out_t    res;
    cr = clamp_q428(longint'(view_real_left) + longint'(pix.pixel_x) * longint'(view_real_step));
    ci = clamp_q428(longint'(view_imag_top) + longint'(pix.pixel_y) * longint'(view_imag_step));
    zr = cr;
    zi = ci;
    rounds = 0;
    escaped = 1'b0;
    while (!escaped && rounds < MAX_ITER) begin
      nr = clamp_q428(((zr * zr - zi * zi) >>> Q_FRAC) + cr);
      ni = clamp_q428(((zr * zi) >>> (Q_FRAC - 1)) + ci);
      zr = nr;
      zi = ni;
      mag = zr * zr + zi * zi;
      if (mag > ESC_LIMIT) begin
        escaped = 1'b1;
      end else begin
        rounds++;
      end
    end
    res.escape_count = (rounds > COUNT_SAT) ? CNT_OUT_W'(COUNT_SAT) : CNT_OUT_W'(rounds);
    res.plot         = (rounds == 0 || rounds == MAX_ITER);
    res.out_x        = pix.pixel_x;
    res.out_y        = pix.pixel_y;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // driver: next item goes up at the falling edge once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (pending_pixels.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        start   <= 1'b1;
        in_item <= pending_pixels.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, check on strobe
  always @(posedge clk) begin
    mbe_out_t want;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (start && !busy) begin
        expected_results.push_back(escape_result(in_item));
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result x=%0d y=%0d with no item pending",
                                    out_item.out_x, out_item.out_y));
        end else begin
          want = expected_results.pop_front();
          if (out_item.escape_count !== want.escape_count) begin
            report_mismatch($sformatf("escape_count %0d, want %0d (x=%0d y=%0d)",
                                      out_item.escape_count, want.escape_count,
                                      want.out_x, want.out_y));
          end
          if (out_item.plot !== want.plot) begin
            report_mismatch($sformatf("plot %b, want %b (x=%0d y=%0d)",
                                      out_item.plot, want.plot, want.out_x, want.out_y));
          end
          if (out_item.out_x !== want.out_x) begin
            report_mismatch($sformatf("out_x %0d, want %0d", out_item.out_x, want.out_x));
          end
          if (out_item.out_y !== want.out_y) begin
            report_mismatch($sformatf("out_y %0d, want %0d", out_item.out_y, want.out_y));
          end
        end
      end
    end
  end

  task automatic push_pixel(input int px, input int py);
    mbe_in_t pix;
    pix.pixel_x = COORD_W'(px);
    pix.pixel_y = COORD_W'(py);
    pending_pixels.push_back(pix);
  endtask

  task automatic push_random_pixels(input int n);
    int px, py;
    repeat (n) begin
      px = $urandom_range(1023, 0);
      py = $urandom_range(1023, 0);
      // pull some coordinates onto the edges
      if ($urandom_range(15, 0) == 0) px = ($urandom_range(1, 0) != 0) ? 1023 : 0;
      if ($urandom_range(15, 0) == 0) py = ($urandom_range(1, 0) != 0) ? 1023 : 0;
      push_pixel(px, py);
    end
  endtask

  // sender holds off until every queued item is done and the unit is idle
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || start || expected_results.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_view_reg(input cfg_idx_t idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REAL_LEFT: view_real_left = val;
      CFG_REAL_STEP: view_real_step = val;
      CFG_IMAG_TOP:  view_imag_top  = val;
      CFG_IMAG_STEP: view_imag_step = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_view(input logic [WORD_W-1:0] left, input logic [WORD_W-1:0] rstep,
                           input logic [WORD_W-1:0] top, input logic [WORD_W-1:0] istep);
    write_view_reg(CFG_REAL_LEFT, left);
    write_view_reg(CFG_REAL_STEP, rstep);
    write_view_reg(CFG_IMAG_TOP, top);
    write_view_reg(CFG_IMAG_STEP, istep);
  endtask

  // window near the set, or any register values at all when wild
  task automatic load_random_view(input bit wild);
    int left, rstep, top, istep;
    if (wild) begin
      left  = $urandom;
      rstep = $urandom;
      top   = $urandom;
      istep = $urandom;
    end else begin
      left  = -671088640 + int'($urandom_range(939524096, 0));
      rstep = int'($urandom_range(2097152, 0)) - 1048576;
      top   = -402653184 + int'($urandom_range(805306368, 0));
      istep = int'($urandom_range(2097152, 0)) - 1048576;
    end
    load_view(left, rstep, top, istep);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset window: corners, origin, c near -1 and a few interior points
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(0, 1023);
    push_pixel(1023, 0);
    push_pixel(427, 240);
    push_pixel(213, 240);
    push_pixel(341, 170);
    push_pixel(512, 512);
    push_pixel(1, 1);
    wait_drained();

    // -8..8 window in 1/64 steps: iterate saturation, c = 0, c = -1, c = 1.5
    load_view(32'h8000_0000, 32'h0040_0000, 32'h7fff_ffff, 32'hffc0_0000);
    push_pixel(0, 512);
    push_pixel(512, 512);
    push_pixel(448, 512);
    push_pixel(608, 512);
    push_random_pixels(150);
    wait_drained();

    // mapping saturates in both directions
    load_view(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    push_random_pixels(40);
    wait_drained();
    load_view(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    push_random_pixels(40);
    wait_drained();

    // every pixel maps to c = 0 and never escapes
    load_view('0, '0, '0, '0);
    push_pixel(0, 0);
    push_pixel(1023, 1023);
    push_pixel(700, 3);
    wait_drained();

    load_view(RST_REAL_LEFT, RST_REAL_STEP, RST_IMAG_TOP, RST_IMAG_STEP);
    push_random_pixels(380);
    wait_drained();

    send_idle_pct = 57;
    repeat (6) begin
      load_random_view(1'b0);
      push_random_pixels(105);
      wait_drained();
    end

    send_idle_pct = 0;
    repeat (5) begin
      load_random_view(1'b0);
      push_random_pixels(105);
      wait_drained();
    end
    load_random_view(1'b1);
    push_random_pixels(105);
    wait_drained();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[mandelbrot_escape_time_unit] OK");
    end else begin
      $display("[mandelbrot_escape_time_unit] ERROR");
    end
    $finish;
  end

endmodule
